// ===== src/pan_tilt_target_tracker_top_assert.svh =====
// Assertion macros used by the tracker RTL (ptt_ser).
`ifndef PAN_TILT_TARGET_TRACKER_TOP_ASSERT_SVH
`define PAN_TILT_TARGET_TRACKER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/ptt_pkg.sv =====
`timescale 1ns / 1ps

package ptt_pkg;

    localparam int DIM_W   = 10;
    localparam int BYTE_W  = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH  = 10'd320;
    localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT = 10'd240;
    localparam logic [BYTE_W-1:0] RST_PAN_CHANNEL  = 8'd7;
    localparam logic [BYTE_W-1:0] RST_TILT_CHANNEL = 8'd0;
    localparam logic [BYTE_W-1:0] RST_TILT_LOW     = 8'd75;
    localparam logic [BYTE_W-1:0] RST_SEND_CAP     = 8'd254;
    localparam logic [BYTE_W-1:0] RST_POSITION     = 8'd128;
    localparam logic [BYTE_W-1:0] SYNC_BYTE        = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_PAN_CHANNEL  = 3'd2,
        CFG_TILT_CHANNEL = 3'd3,
        CFG_TILT_LOW     = 3'd4,
        CFG_SEND_CAP     = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        SLOT_PAN_SYNC  = 3'd0,
        SLOT_PAN_CHAN  = 3'd1,
        SLOT_PAN_POS   = 3'd2,
        SLOT_TILT_SYNC = 3'd3,
        SLOT_TILT_CHAN = 3'd4,
        SLOT_TILT_POS  = 3'd5
    } t_slot;

    typedef struct packed {
        logic [DIM_W-1:0]  image_width;
        logic [DIM_W-1:0]  image_height;
        logic [BYTE_W-1:0] pan_channel;
        logic [BYTE_W-1:0] tilt_channel;
        logic [BYTE_W-1:0] tilt_low;
        logic [BYTE_W-1:0] send_cap;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] pan_chan;
        logic [BYTE_W-1:0] pan_byte;
        logic [BYTE_W-1:0] tilt_chan;
        logic [BYTE_W-1:0] tilt_byte;
    } t_cmd;

endpackage

// ===== src/ptt_cfg_regs.sv =====
`timescale 1ns / 1ps

module ptt_cfg_regs
    import ptt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_IMAGE_WIDTH:  n_cfg.image_width  = i_cfg_data;
                CFG_IMAGE_HEIGHT: n_cfg.image_height = i_cfg_data;
                CFG_PAN_CHANNEL:  n_cfg.pan_channel  = i_cfg_data[BYTE_W-1:0];
                CFG_TILT_CHANNEL: n_cfg.tilt_channel = i_cfg_data[BYTE_W-1:0];
                CFG_TILT_LOW:     n_cfg.tilt_low     = i_cfg_data[BYTE_W-1:0];
                CFG_SEND_CAP:     n_cfg.send_cap     = i_cfg_data[BYTE_W-1:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width  <= RST_IMAGE_WIDTH;
            r_cfg.image_height <= RST_IMAGE_HEIGHT;
            r_cfg.pan_channel  <= RST_PAN_CHANNEL;
            r_cfg.tilt_channel <= RST_TILT_CHANNEL;
            r_cfg.tilt_low     <= RST_TILT_LOW;
            r_cfg.send_cap     <= RST_SEND_CAP;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== src/ptt_track.sv =====
`timescale 1ns / 1ps

module ptt_track
    import ptt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_found,
    input  logic [DIM_W-1:0]  i_box_x,
    input  logic [DIM_W-1:0]  i_box_y,
    input  logic [DIM_W-1:0]  i_box_width,
    input  logic [DIM_W-1:0]  i_box_height,
    input  t_cfg              i_cfg,
    input  logic              i_ser_free,
    output logic              o_load,
    output t_cmd              o_cmd
);

    // |v| / 10 for |v| < 2048, exact floor via 6554 / 2^16
    function automatic logic [BYTE_W-1:0] div10(input logic [DIM_W:0] mag);
        logic [23:0] prod;
        prod = {13'd0, mag} * 24'd6554;
        return prod[23:16];
    endfunction

    logic              r_valid;
    logic              r_found;
    logic [DIM_W-1:0]  r_box_x;
    logic [DIM_W-1:0]  r_box_y;
    logic [DIM_W-1:0]  r_box_width;
    logic [DIM_W-1:0]  r_box_height;
    logic [BYTE_W-1:0] r_pan;
    logic [BYTE_W-1:0] r_tilt;
    logic [BYTE_W-1:0] n_pan;
    logic [BYTE_W-1:0] n_tilt;

    logic              advance;
    logic              accept;
    logic [DIM_W:0]    ctr_x;
    logic [DIM_W:0]    ctr_y;
    logic signed [DIM_W+1:0] dx;
    logic signed [DIM_W+1:0] dy;
    logic signed [DIM_W+1:0] dx_neg;
    logic signed [DIM_W+1:0] dy_neg;
    logic [DIM_W:0]    mag_x;
    logic [DIM_W:0]    mag_y;
    logic [BYTE_W-1:0] q_x;
    logic [BYTE_W-1:0] q_y;
    logic signed [DIM_W-1:0] sum_pan;
    logic signed [DIM_W-1:0] sum_tilt;

    assign advance = r_valid && (!r_found || i_ser_free);
    assign o_stall = r_valid && !advance;
    assign accept  = i_valid && !o_stall;
    assign o_load  = r_valid && r_found && i_ser_free;

    always_comb begin
        ctr_x  = {1'b0, r_box_x} + {2'b0, r_box_width[DIM_W-1:1]};
        ctr_y  = {1'b0, r_box_y} + {2'b0, r_box_height[DIM_W-1:1]};
        dx     = $signed({3'b0, i_cfg.image_width[DIM_W-1:1]}) - $signed({1'b0, ctr_x});
        dy     = $signed({3'b0, i_cfg.image_height[DIM_W-1:1]}) - $signed({1'b0, ctr_y});
        dx_neg = -dx;
        dy_neg = -dy;
        mag_x  = dx[DIM_W+1] ? dx_neg[DIM_W:0] : dx[DIM_W:0];
        mag_y  = dy[DIM_W+1] ? dy_neg[DIM_W:0] : dy[DIM_W:0];
        q_x    = div10(mag_x);
        q_y    = div10(mag_y);

        // pan moves against dx, tilt moves with dy
        sum_pan  = dx[DIM_W+1] ? $signed({2'b0, r_pan}) + $signed({2'b0, q_x})
                               : $signed({2'b0, r_pan}) - $signed({2'b0, q_x});
        sum_tilt = dy[DIM_W+1] ? $signed({2'b0, r_tilt}) - $signed({2'b0, q_y})
                               : $signed({2'b0, r_tilt}) + $signed({2'b0, q_y});

        if (sum_pan > 10'sd255) begin
            n_pan = 8'd255;
        end else if (sum_pan < 10'sd0) begin
            n_pan = 8'd0;
        end else begin
            n_pan = sum_pan[BYTE_W-1:0];
        end

        if (sum_tilt > 10'sd255) begin
            n_tilt = 8'd255;
        end else if (sum_tilt < $signed({2'b0, i_cfg.tilt_low})) begin
            n_tilt = i_cfg.tilt_low;
        end else begin
            n_tilt = sum_tilt[BYTE_W-1:0];
        end

        o_cmd.pan_chan  = i_cfg.pan_channel;
        o_cmd.pan_byte  = (n_pan > i_cfg.send_cap) ? i_cfg.send_cap : n_pan;
        o_cmd.tilt_chan = i_cfg.tilt_channel;
        o_cmd.tilt_byte = (n_tilt > i_cfg.send_cap) ? i_cfg.send_cap : n_tilt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pan   <= RST_POSITION;
            r_tilt  <= RST_POSITION;
        end else begin
            if (accept) begin
                r_valid <= 1'b1;
            end else if (advance) begin
                r_valid <= 1'b0;
            end
            if (o_load) begin
                r_pan  <= n_pan;
                r_tilt <= n_tilt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_found      <= i_found;
            r_box_x      <= i_box_x;
            r_box_y      <= i_box_y;
            r_box_width  <= i_box_width;
            r_box_height <= i_box_height;
        end
    end

endmodule

// ===== src/ptt_ser.sv =====
`timescale 1ns / 1ps
`include "pan_tilt_target_tracker_top_assert.svh"

module ptt_ser
    import ptt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    output logic              o_free,
    input  t_cmd              i_cmd,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [BYTE_W-1:0] o_command_byte,
    output logic              o_last_byte
);

    logic  r_valid;
    t_slot r_slot;
    t_cmd  r_cmd;
    logic  take;

    assign take    = r_valid && !i_stall;
    assign o_free  = !r_valid || (take && r_slot == SLOT_TILT_POS);
    assign o_valid = r_valid;
    assign o_last_byte = (r_slot == SLOT_TILT_POS);

    always_comb begin
        case (r_slot)
            SLOT_PAN_SYNC:  o_command_byte = SYNC_BYTE;
            SLOT_PAN_CHAN:  o_command_byte = r_cmd.pan_chan;
            SLOT_PAN_POS:   o_command_byte = r_cmd.pan_byte;
            SLOT_TILT_SYNC: o_command_byte = SYNC_BYTE;
            SLOT_TILT_CHAN: o_command_byte = r_cmd.tilt_chan;
            SLOT_TILT_POS:  o_command_byte = r_cmd.tilt_byte;
            default:        o_command_byte = SYNC_BYTE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_slot  <= SLOT_PAN_SYNC;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_slot  <= SLOT_PAN_SYNC;
        end else if (take) begin
            if (r_slot == SLOT_TILT_POS) begin
                r_valid <= 1'b0;
                r_slot  <= SLOT_PAN_SYNC;
            end else begin
                r_slot  <= t_slot'(r_slot + 3'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cmd <= i_cmd;
        end
    end

    `ASSERT_IMP(a_slot_range, i_clk, i_rst_n, 1'b1, r_slot <= SLOT_TILT_POS)
    `ASSERT_IMP(a_load_when_free, i_clk, i_rst_n, i_load, o_free)
    `ASSERT_NEXT(a_load_starts, i_clk, i_rst_n, i_load, r_valid && r_slot == SLOT_PAN_SYNC)
    `ASSERT_NEXT(a_hold_on_stall, i_clk, i_rst_n, r_valid && i_stall && !i_load, $stable(r_slot) && r_valid)
    `ASSERT_NEXT(a_drain, i_clk, i_rst_n, take && r_slot == SLOT_TILT_POS && !i_load, !r_valid)

endmodule

// ===== src/pan_tilt_target_tracker_top.sv =====
`timescale 1ns / 1ps
// channel | handshake                  | payload
// --------+----------------------------+----------------------------------------------
// input   | i_valid / o_stall          | i_found, i_box_x, i_box_y, i_box_width, i_box_height
// output  | o_valid / i_stall          | o_command_byte, o_last_byte
// config  | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A detection waits in the input register until the serializer is free, then is loaded.
// A found item sends six bytes via the serializer, one per cycle while i_stall is low;
// an item without a box sends no bytes.
// The next item is taken while the last byte of the current one is being delivered.
// Synchronous active-low reset: positions 128, registers to their defaults.
// o_stall is high while a found item waits on the serializer; on the last byte it follows i_stall.

module pan_tilt_target_tracker_top
    import ptt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_found,
    input  logic [DIM_W-1:0]     i_box_x,
    input  logic [DIM_W-1:0]     i_box_y,
    input  logic [DIM_W-1:0]     i_box_width,
    input  logic [DIM_W-1:0]     i_box_height,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [BYTE_W-1:0]    o_command_byte,
    output logic                 o_last_byte,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data
);

    t_cfg cfg;
    t_cmd cmd;
    logic ser_load;
    logic ser_free;

    ptt_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ptt_track u_track (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_found      (i_found),
        .i_box_x      (i_box_x),
        .i_box_y      (i_box_y),
        .i_box_width  (i_box_width),
        .i_box_height (i_box_height),
        .i_cfg        (cfg),
        .i_ser_free   (ser_free),
        .o_load       (ser_load),
        .o_cmd        (cmd)
    );

    ptt_ser u_ser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (ser_load),
        .o_free         (ser_free),
        .i_cmd          (cmd),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_command_byte (o_command_byte),
        .o_last_byte    (o_last_byte)
    );

endmodule
